@@ rtl/kfc_pkg.sv @@
package kfc_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_EQU  = 3'd4;
    localparam logic [2:0] OP_NONE = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_EQU   = 2'd2;
    localparam logic [1:0] MODE_OPER  = 2'd3;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_rsp_t;

endpackage

@@ rtl/kfc_muldiv.sv @@
module kfc_muldiv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kfc_pkg::md_req_t            req,
    input  logic [kfc_pkg::DATA_W-1:0]  a_in,
    input  logic [kfc_pkg::DATA_W-1:0]  b_in,
    output kfc_pkg::md_rsp_t            rsp,
    output logic [kfc_pkg::DATA_W-1:0]  result
);
    import kfc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] mag_a, mag_b;

    // partial remainder with next dividend bit, minus divisor
    assign trial = {acc_reg, x_reg[DATA_W-1]} - {1'b0, y_reg};
    assign mag_a = a_in[DATA_W-1] ? (~a_in + 1'b1) : a_in;
    assign mag_b = b_in[DATA_W-1] ? (~b_in + 1'b1) : b_in;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = req.is_div;
            neg_next  = a_in[DATA_W-1] ^ b_in[DATA_W-1];
            acc_next  = '0;
            x_next    = req.is_div ? mag_a : a_in;
            y_next    = req.is_div ? mag_b : b_in;
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!trial[DATA_W]) begin
                    acc_next = trial[DATA_W-1:0];
                    x_next   = {x_reg[DATA_W-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[DATA_W-2:0], x_reg[DATA_W-1]};
                    x_next   = {x_reg[DATA_W-2:0], 1'b0};
                end
            end else begin
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[DATA_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[DATA_W-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = div_reg ? (neg_reg ? (~x_reg + 1'b1) : x_reg) : acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg && !done_reg)
        else $error("unit started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished run");
    a_done_count: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> cnt_reg == '0)
        else $error("run ended early");

endmodule

@@ rtl/keypad_four_function_calculator.sv @@
// digit keys and add or subtract evaluations give their word in the cycle after acceptance
// a multiply or divide evaluation gives its word after the multiply/divide unit has raised done
// throughput: one key per cycle while the output is free; while a multiply or divide is evaluated,
// no key is taken until the bit-serial multiply/divide unit, which retires one bit per cycle, is done
// reset: aresetn is synchronous, active low; operands clear, no operator pending, entry on
// the first operand, no word pending at the output
module keypad_four_function_calculator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // digit_value[3:0], op_code[6:4], zero [7]
    input  logic        s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // shown_value[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import kfc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic              st_reg, st_next;
    logic [DATA_W-1:0] first_reg, first_next;
    logic [DATA_W-1:0] second_reg, second_next;
    logic [2:0]        pend_reg, pend_next;
    logic [1:0]        mode_reg, mode_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    logic              cmd;
    logic [3:0]        digit_value;
    logic [2:0]        op_code;
    logic              in_acc;
    logic              out_free;
    logic [DATA_W-1:0] opnd;
    logic [DATA_W-1:0] entry;
    logic [DATA_W-1:0] addsub;
    logic              do_eval;
    md_req_t           md_req;
    md_rsp_t           md_rsp;
    logic [DATA_W-1:0] md_result;

    assign cmd         = s_tuser;
    assign digit_value = s_tdata[3:0];
    assign op_code     = s_tdata[6:4];
    assign out_free    = !m_valid_reg || m_tready;
    assign s_tready    = (st_reg == S_IDLE) && out_free && !md_rsp.busy && !md_rsp.done;
    assign in_acc      = s_tvalid && s_tready;

    // digit entry: masked times ten plus digit, also the wrapped new value
    assign opnd  = mode_reg[1] ? '0 : (mode_reg[0] ? second_reg : first_reg);
    assign entry = {opnd[DATA_W-4:0], 3'b000} + {opnd[DATA_W-2:0], 1'b0}
                   + {{(DATA_W-4){1'b0}}, digit_value};
    assign addsub = (pend_reg == OP_SUB) ? (first_reg - second_reg)
                                         : (first_reg + second_reg);
    assign do_eval = cmd && ((op_code == OP_EQU) || ((op_code < OP_EQU) && mode_reg[0]));

    always_comb begin
        st_next      = st_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        pend_next    = pend_reg;
        mode_next    = mode_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        md_req.start  = 1'b0;
        md_req.is_div = 1'b0;
        if (in_acc) begin
            if (!cmd) begin
                mode_next    = {1'b0, mode_reg[0]};
                m_valid_next = 1'b1;
                if (entry[DATA_W-1]) begin
                    m_data_next = '0;
                    m_user_next = ST_OVF;
                end else begin
                    m_data_next = entry;
                    m_user_next = ST_OK;
                    if (mode_reg[0]) begin
                        second_next = entry;
                    end else begin
                        first_next = entry;
                    end
                end
            end else if (op_code > OP_EQU) begin
                m_valid_next = 1'b1;
                m_data_next  = mode_reg[0] ? second_reg : first_reg;
                m_user_next  = ST_OK;
            end else begin
                if (op_code == OP_EQU) begin
                    mode_next = MODE_EQU;
                end else begin
                    pend_next = op_code;
                    mode_next = MODE_OPER;
                end
                if (!do_eval) begin
                    second_next  = first_reg;
                    m_valid_next = 1'b1;
                    m_data_next  = first_reg;
                    m_user_next  = ST_OK;
                end else begin
                    unique case (pend_reg)
                        OP_ADD, OP_SUB: begin
                            first_next   = addsub;
                            m_valid_next = 1'b1;
                            m_data_next  = addsub;
                            m_user_next  = ST_OK;
                        end
                        OP_MUL: begin
                            md_req.start = 1'b1;
                            st_next      = S_BUSY;
                        end
                        OP_DIV: begin
                            if (second_reg == '0) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '0;
                                m_user_next  = ST_DIV0;
                            end else begin
                                md_req.start  = 1'b1;
                                md_req.is_div = 1'b1;
                                st_next       = S_BUSY;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = first_reg;
                            m_user_next  = ST_OK;
                        end
                    endcase
                end
            end
        end else if ((st_reg == S_BUSY) && md_rsp.done) begin
            st_next      = S_IDLE;
            first_next   = md_result;
            m_valid_next = 1'b1;
            m_data_next  = md_result;
            m_user_next  = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            first_reg   <= '0;
            second_reg  <= '0;
            pend_reg    <= OP_NONE;
            mode_reg    <= MODE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            pend_reg    <= pend_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    kfc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .a_in    (first_reg),
        .b_in    (second_reg),
        .rsp     (md_rsp),
        .result  (md_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_start_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        md_req.start |-> st_reg == S_IDLE && cmd && (pend_reg == OP_MUL || pend_reg == OP_DIV))
        else $error("multiply/divide started outside an evaluation");
    a_done_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> st_reg == S_BUSY)
        else $error("unit finished with no evaluation waiting");
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> m_tdata == '0)
        else $error("error word carries a value");
    a_busy_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_BUSY && !md_rsp.done) |=> !$rose(m_tvalid))
        else $error("word produced during a multiply/divide run");

endmodule
